// ----- rtl/core/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types and codes of the periodic task scheduler: opcodes, status
// codes, field widths and the request and response words between modules.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int TimeW = 32;
	localparam int ValW  = 16;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_RETIRE = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_MISS   = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_BADPAR = 3'd4;
	localparam logic [2:0] ST_HALTED = 3'd5;
	localparam logic [2:0] ST_BADIDX = 3'd6;

	typedef struct packed {
		logic             start;
		logic [TimeW-1:0] dividend;
		logic [ValW-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic            done;
		logic [ValW-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic            per_we;
		logic            bud_we;
		logic            rem_we;
		logic [ValW-1:0] per;
		logic [ValW-1:0] bud;
		logic [ValW-1:0] rem;
	} tbl_wr_t;

	typedef struct packed {
		logic [ValW-1:0] per;
		logic [ValW-1:0] bud;
		logic [ValW-1:0] rem;
	} tbl_rd_t;

endpackage

// ----- rtl/core/pst_divider.sv -----
// ----------------------------------------------------------------------------
// pst_divider
// Iterative remainder unit: timer modulo period, two quotient bits per cycle
// by restoring subtraction.
// ----------------------------------------------------------------------------
module pst_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  pst_pkg::div_req_t  req,
	output pst_pkg::div_rsp_t  rsp
);
	import pst_pkg::*;

	localparam int Steps = TimeW / 2;
	localparam int CntW  = $clog2(Steps);

	logic             busy_q;
	logic             done_q;
	logic [CntW-1:0]  cnt_q;
	logic [TimeW-1:0] num_q;
	logic [ValW-1:0]  div_q;
	logic [ValW-1:0]  rem_q;

	logic [ValW:0] t1, r1, t2, r2;

	always_comb begin
		t1 = {rem_q, num_q[TimeW-1]};
		r1 = (t1 >= {1'b0, div_q}) ? t1 - {1'b0, div_q} : t1;
		t2 = {r1[ValW-1:0], num_q[TimeW-2]};
		r2 = (t2 >= {1'b0, div_q}) ? t2 - {1'b0, div_q} : t2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == CntW'(Steps - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CntW'(Steps - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 2;
			rem_q <= r2[ValW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < div_q))
		else $error("remainder not below divisor");

	a_no_start_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running request");

endmodule

// ----- rtl/core/pst_task_table.sv -----
// ----------------------------------------------------------------------------
// pst_task_table
// Task storage: period, budget and remaining work memories with one write
// and one registered read port. Remaining work carries a valid bit per entry
// so that reset and clear empty it at once.
// ----------------------------------------------------------------------------
module pst_task_table #(
	parameter int MAX_TASKS = 8,
	localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              clear_all,
	input  pst_pkg::tbl_wr_t  wr,
	input  logic [IdxW-1:0]   wr_idx,
	input  logic [IdxW-1:0]   rd_idx,
	output pst_pkg::tbl_rd_t  rd
);
	import pst_pkg::*;

	logic [ValW-1:0] per_mem [MAX_TASKS];
	logic [ValW-1:0] bud_mem [MAX_TASKS];
	logic [ValW-1:0] rem_mem [MAX_TASKS];

	logic [MAX_TASKS-1:0] rem_vld_q;
	logic [ValW-1:0]      rd_per_q;
	logic [ValW-1:0]      rd_bud_q;
	logic [ValW-1:0]      rd_rem_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.per_we) per_mem[wr_idx] <= wr.per;
		if (wr.bud_we) bud_mem[wr_idx] <= wr.bud;
		if (wr.rem_we) rem_mem[wr_idx] <= wr.rem;
		rd_per_q <= per_mem[rd_idx];
		rd_bud_q <= bud_mem[rd_idx];
		rd_rem_q <= rem_mem[rd_idx];
		rd_vld_q <= rem_vld_q[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_vld_q <= '0;
		end else if (clear_all) begin
			rem_vld_q <= '0;
		end else if (wr.rem_we) begin
			rem_vld_q[wr_idx] <= 1'b1;
		end
	end

	// An entry never written since reset or clear holds no work.
	assign rd.per = rd_per_q;
	assign rd.bud = rd_bud_q;
	assign rd.rem = rd_vld_q ? rd_rem_q : '0;

endmodule

// ----- rtl/core/periodic_task_scheduler_rm_edf_unit.sv -----
// ----------------------------------------------------------------------------
// periodic_task_scheduler_rm_edf_unit
// Periodic task scheduler with rate monotonic or earliest deadline first pick.
// ----------------------------------------------------------------------------
// Input words (opcode, task_period, task_budget, task_index) enter on
// in_valid while in_stall is low; each word gives exactly one result word on
// out_valid (status, chosen_task, done_count, all_done, tick_time), held until
// out_stall is low. The policy register is written on cfg_valid with
// cfg_ready, which is always high; write it only while the block is idle.
// Add, retire and clear words go from accept through S_FINISH to the output
// register. A tick walks the live tasks in order with one shared remainder
// unit: a table read, a divider run and a compare per live task, while a
// retired task is only skipped. One word is worked on at a time; in_stall
// stays high until its result sits in the output register, and the next
// word may then be taken while that result still waits on out_stall. Reset
// empties the task table, zeroes the timer and counters, releases the
// deadline-miss latch and selects rate monotonic order.
// ----------------------------------------------------------------------------
module periodic_task_scheduler_rm_edf_unit #(
	parameter int MAX_TASKS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 opcode,
	input  logic [pst_pkg::ValW-1:0]   task_period,
	input  logic [pst_pkg::ValW-1:0]   task_budget,
	input  logic [2:0]                 task_index,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [2:0]                 status,
	output logic [2:0]                 chosen_task,
	output logic [3:0]                 done_count,
	output logic                       all_done,
	output logic [pst_pkg::TimeW-1:0]  tick_time,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_data
);
	import pst_pkg::*;

	localparam int IdxW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CntW = $clog2(MAX_TASKS + 1);
	localparam int CmpW = (CntW > 3) ? CntW : 3;

	typedef enum logic [2:0] {S_IDLE, S_SCAN, S_READ, S_DIV, S_FINISH} state_t;

	state_t               state_q;
	logic                 policy_q;
	logic [TimeW-1:0]     timer_q;
	logic [CntW-1:0]      task_cnt_q;
	logic [CntW-1:0]      ret_cnt_q;
	logic [MAX_TASKS-1:0] retired_q;
	logic                 miss_q;
	logic [CntW-1:0]      scan_q;
	logic                 found_q;
	logic [ValW-1:0]      best_key_q;
	logic [IdxW-1:0]      best_idx_q;
	logic [ValW-1:0]      best_work_q;
	logic [2:0]           res_status_q;
	logic [IdxW-1:0]      res_chosen_q;
	logic [TimeW-1:0]     res_time_q;
	logic                 out_valid_q;
	logic [2:0]           status_q;
	logic [2:0]           chosen_q;
	logic [3:0]           done_cnt_q;
	logic                 all_done_q;
	logic [TimeW-1:0]     tick_time_q;

	logic            accept;
	logic [IdxW-1:0] scan_idx;
	logic [IdxW-1:0] add_idx;
	logic [IdxW-1:0] ret_idx;
	logic            ret_ok;
	logic            tbl_full;
	logic            add_bad;
	logic            scan_end;
	logic [ValW-1:0] phase;
	logic            due;
	logic [ValW-1:0] work;
	logic [ValW-1:0] key;
	logic            better;

	tbl_wr_t         tbl_wr;
	logic [IdxW-1:0] tbl_wr_idx;
	tbl_rd_t         tbl_rd;
	logic            clear_all;
	div_req_t        div_req;
	div_rsp_t        div_rsp;

	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign scan_idx = scan_q[IdxW-1:0];
	assign add_idx  = task_cnt_q[IdxW-1:0];
	assign ret_idx  = IdxW'(task_index);
	assign ret_ok   = CmpW'(task_index) < CmpW'(task_cnt_q);
	assign tbl_full = (task_cnt_q == CntW'(MAX_TASKS));
	assign add_bad  = (task_budget == '0) || (task_period < task_budget);
	assign scan_end = (scan_q >= task_cnt_q);

	// A task is due when its period divides the timer; it is then refilled if no work is left.
	assign phase  = div_rsp.rem;
	assign due    = (phase == '0);
	assign work   = due ? tbl_rd.bud : tbl_rd.rem;
	assign key    = policy_q ? (tbl_rd.per - phase) : tbl_rd.per;
	assign better = !found_q || (key < best_key_q);

	assign clear_all = accept && (opcode == OP_CLEAR);

	always_comb begin
		tbl_wr     = '0;
		tbl_wr_idx = add_idx;
		if (accept && (opcode == OP_ADD) && !tbl_full && !add_bad) begin
			tbl_wr.per_we = 1'b1;
			tbl_wr.bud_we = 1'b1;
			tbl_wr.rem_we = 1'b1;
			tbl_wr.per    = task_period;
			tbl_wr.bud    = task_budget;
		end else if ((state_q == S_DIV) && div_rsp.done && due && (tbl_rd.rem == '0)) begin
			tbl_wr.rem_we = 1'b1;
			tbl_wr.rem    = tbl_rd.bud;
			tbl_wr_idx    = scan_idx;
		end else if ((state_q == S_SCAN) && scan_end && found_q) begin
			tbl_wr.rem_we = 1'b1;
			tbl_wr.rem    = best_work_q - 1'b1;
			tbl_wr_idx    = best_idx_q;
		end
	end

	assign div_req.start    = (state_q == S_READ) && (tbl_rd.per != '0);
	assign div_req.dividend = timer_q;
	assign div_req.divisor  = tbl_rd.per;

	pst_task_table #(
		.MAX_TASKS(MAX_TASKS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear_all(clear_all),
		.wr       (tbl_wr),
		.wr_idx   (tbl_wr_idx),
		.rd_idx   (scan_idx),
		.rd       (tbl_rd)
	);

	pst_divider u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			policy_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			timer_q      <= '0;
			task_cnt_q   <= '0;
			ret_cnt_q    <= '0;
			retired_q    <= '0;
			miss_q       <= 1'b0;
			scan_q       <= '0;
			found_q      <= 1'b0;
			best_key_q   <= '0;
			best_idx_q   <= '0;
			best_work_q  <= '0;
			res_status_q <= ST_OK;
			res_chosen_q <= '0;
			res_time_q   <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			chosen_q     <= '0;
			done_cnt_q   <= '0;
			all_done_q   <= 1'b0;
			tick_time_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_FINISH)) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_time_q <= timer_q;
						unique case (opcode)
							OP_TICK: begin
								res_chosen_q <= '0;
								if (miss_q) begin
									res_status_q <= ST_HALTED;
									state_q      <= S_FINISH;
								end else begin
									res_status_q <= ST_OK;
									scan_q       <= '0;
									found_q      <= 1'b0;
									state_q      <= S_SCAN;
								end
							end
							OP_ADD: begin
								state_q <= S_FINISH;
								if (tbl_full) begin
									res_status_q <= ST_FULL;
									res_chosen_q <= '0;
								end else if (add_bad) begin
									res_status_q <= ST_BADPAR;
									res_chosen_q <= '0;
								end else begin
									res_status_q       <= ST_OK;
									res_chosen_q       <= add_idx;
									retired_q[add_idx] <= 1'b0;
									task_cnt_q         <= task_cnt_q + 1'b1;
								end
							end
							OP_RETIRE: begin
								state_q <= S_FINISH;
								if (!ret_ok) begin
									res_status_q <= ST_BADIDX;
									res_chosen_q <= '0;
								end else begin
									res_status_q <= ST_OK;
									res_chosen_q <= ret_idx;
									if (!retired_q[ret_idx]) begin
										retired_q[ret_idx] <= 1'b1;
										ret_cnt_q          <= ret_cnt_q + 1'b1;
									end
								end
							end
							OP_CLEAR: begin
								res_status_q <= ST_OK;
								res_chosen_q <= '0;
								state_q      <= S_FINISH;
								task_cnt_q   <= '0;
								ret_cnt_q    <= '0;
								retired_q    <= '0;
								timer_q      <= '0;
								miss_q       <= 1'b0;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						timer_q <= timer_q + 1'b1;
						if (found_q) begin
							res_chosen_q <= best_idx_q;
						end else begin
							res_status_q <= ST_IDLE;
						end
						state_q <= S_FINISH;
					end else if (retired_q[scan_idx]) begin
						scan_q <= scan_q + 1'b1;
					end else begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					if (tbl_rd.per == '0) begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						if (due && (tbl_rd.rem != '0)) begin
							// Work left from the last period: latch the miss and stop.
							miss_q       <= 1'b1;
							res_status_q <= ST_MISS;
							res_chosen_q <= scan_idx;
							state_q      <= S_FINISH;
						end else begin
							if ((work != '0) && better) begin
								found_q     <= 1'b1;
								best_key_q  <= key;
								best_idx_q  <= scan_idx;
								best_work_q <= work;
							end
							scan_q  <= scan_q + 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_FINISH: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						chosen_q    <= 3'(res_chosen_q);
						done_cnt_q  <= 4'(ret_cnt_q);
						all_done_q  <= (task_cnt_q != '0) && (ret_cnt_q == task_cnt_q);
						tick_time_q <= res_time_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign chosen_task = chosen_q;
	assign done_count  = done_cnt_q;
	assign all_done    = all_done_q;
	assign tick_time   = tick_time_q;

	a_miss_reported: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(miss_q) |-> ((state_q == S_FINISH) && (res_status_q == ST_MISS)))
		else $error("deadline miss latched without a miss result");

	a_retired_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ret_cnt_q <= task_cnt_q)
		else $error("more retired tasks than loaded tasks");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		task_cnt_q <= CntW'(MAX_TASKS))
		else $error("task count beyond table size");

endmodule

// ----- tb/tb_periodic_task_scheduler_rm_edf_unit.sv -----
// ----------------------------------------------------------------------------
// tb_periodic_task_scheduler_rm_edf_unit
// Self-checking bench for the periodic task scheduler. A driver feeds command
// words from a queue and a monitor checks every result word, field by field,
// against a cycle-free scheduler predictor kept in step with the accepted
// words. Runs a directed part and then random task sessions under both
// policies and several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_periodic_task_scheduler_rm_edf_unit;
	import pst_pkg::*;

	localparam int SLOTS          = 8;
	localparam int PHASE_WORDS    = 112;
	localparam int HOLD_LEN       = 300;
	localparam int DRAIN_CYCLES   = 200;
	localparam int WATCHDOG_LIMIT = 5000;

	typedef struct packed {
		logic [1:0]      op;
		logic [ValW-1:0] period;
		logic [ValW-1:0] budget;
		logic [2:0]      index;
	} sched_cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [2:0]       chosen;
		logic [3:0]       done;
		logic             all_done;
		logic [TimeW-1:0] tick;
	} sched_rsp_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_stall;
	logic [1:0]          opcode      = '0;
	logic [ValW-1:0]     task_period = '0;
	logic [ValW-1:0]     task_budget = '0;
	logic [2:0]          task_index  = '0;
	logic                out_valid;
	logic                out_stall   = 1'b0;
	logic [2:0]          status;
	logic [2:0]          chosen_task;
	logic [3:0]          done_count;
	logic                all_done;
	logic [TimeW-1:0]    tick_time;
	logic                cfg_valid   = 1'b0;
	logic                cfg_ready;
	logic                cfg_data    = 1'b0;

	// Scheduler state as the predictor sees it.
	logic                policy_edf = 1'b0;
	logic [ValW-1:0]     task_per [SLOTS] = '{default: '0};
	logic [ValW-1:0]     task_bud [SLOTS] = '{default: '0};
	logic [ValW-1:0]     task_left [SLOTS] = '{default: '0};
	logic                task_retired [SLOTS] = '{default: 1'b0};
	int                  n_tasks   = 0;
	int                  n_retired = 0;
	logic [TimeW-1:0]    sched_time = '0;
	logic                miss_hold  = 1'b0;

	sched_cmd_t          cmd_queue[$];
	sched_rsp_t          due_replies[$];
	sched_cmd_t          next_cmd;
	sched_rsp_t          want;
	int                  words_queued  = 0;
	int                  words_taken   = 0;
	int                  phase_words   = 0;
	int                  mismatches    = 0;
	int                  send_idle_pct = 0;
	int                  recv_stall_pct = 0;
	int                  holds_asked   = 0;
	int                  holds_done    = 0;
	int                  hold_left     = 0;
	int                  quiet_cycles  = 0;

	periodic_task_scheduler_rm_edf_unit #(
		.MAX_TASKS(SLOTS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.task_period(task_period),
		.task_budget(task_budget),
		.task_index (task_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.chosen_task(chosen_task),
		.done_count (done_count),
		.all_done   (all_done),
		.tick_time  (tick_time),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one accepted command word to the scheduler state and returns
	// the result word it must produce.
	function automatic sched_rsp_t schedule_step(sched_cmd_t cmd);
		sched_rsp_t      r;
		int              i;
		int              best;
		logic            found;
		logic            stop;
		logic [ValW-1:0] ph;
		logic [ValW-1:0] key;
		logic [ValW-1:0] best_key;

		r.status = ST_OK;
		r.chosen = '0;
		r.tick   = sched_time;
		case (cmd.op)
			OP_TICK: begin
				if (miss_hold) begin
					r.status = ST_HALTED;
				end else begin
					found    = 1'b0;
					stop     = 1'b0;
					best     = 0;
					best_key = '0;
					for (i = 0; i < n_tasks; i++) begin
						if (!stop && !task_retired[i]) begin
							ph = 16'(sched_time % task_per[i]);
							if (ph == 0) begin
								// Work still left from the last period is a missed deadline.
								if (task_left[i] != 0) begin
									miss_hold = 1'b1;
									r.status  = ST_MISS;
									r.chosen  = 3'(i);
									stop      = 1'b1;
								end else begin
									task_left[i] = task_bud[i];
								end
							end
							if (!stop && task_left[i] != 0) begin
								key = policy_edf ? task_per[i] - ph : task_per[i];
								if (!found || key < best_key) begin
									found    = 1'b1;
									best_key = key;
									best     = i;
								end
							end
						end
					end
					if (!stop) begin
						sched_time = sched_time + 1'b1;
						if (!found) begin
							r.status = ST_IDLE;
						end else begin
							task_left[best] = task_left[best] - 1'b1;
							r.chosen = 3'(best);
						end
					end
				end
			end
			OP_ADD: begin
				if (n_tasks >= SLOTS) begin
					r.status = ST_FULL;
				end else if (cmd.budget == 0 || cmd.period < cmd.budget) begin
					r.status = ST_BADPAR;
				end else begin
					task_per[n_tasks]     = cmd.period;
					task_bud[n_tasks]     = cmd.budget;
					task_left[n_tasks]    = '0;
					task_retired[n_tasks] = 1'b0;
					r.chosen = 3'(n_tasks);
					n_tasks++;
				end
			end
			OP_RETIRE: begin
				if (cmd.index >= n_tasks) begin
					r.status = ST_BADIDX;
				end else begin
					if (!task_retired[cmd.index]) begin
						task_retired[cmd.index] = 1'b1;
						n_retired++;
					end
					r.chosen = cmd.index;
				end
			end
			default: begin
				foreach (task_left[i]) begin
					task_left[i]    = '0;
					task_retired[i] = 1'b0;
				end
				n_tasks    = 0;
				n_retired  = 0;
				sched_time = '0;
				miss_hold  = 1'b0;
			end
		endcase
		r.done     = 4'(n_retired);
		r.all_done = (n_tasks > 0 && n_retired == n_tasks);
		return r;
	endfunction

	// Driver: a new word is offered only once the current one is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due_replies.push_back(schedule_step({opcode, task_period, task_budget,
					task_index}));
				words_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_cmd = cmd_queue.pop_front();
					in_valid    <= 1'b1;
					opcode      <= next_cmd.op;
					task_period <= next_cmd.period;
					task_budget <= next_cmd.budget;
					task_index  <= next_cmd.index;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, with one long hold-off to back the block up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (holds_done != holds_asked) begin
				holds_done <= holds_asked;
				hold_left  <= HOLD_LEN;
				out_stall  <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_replies.size() == 0) begin
				$error("result word with no command outstanding");
				mismatches++;
			end else begin
				want = due_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					mismatches++;
				end
				if (chosen_task !== want.chosen) begin
					$error("chosen_task: expected %0d, got %0d", want.chosen, chosen_task);
					mismatches++;
				end
				if (done_count !== want.done) begin
					$error("done_count: expected %0d, got %0d", want.done, done_count);
					mismatches++;
				end
				if (all_done !== want.all_done) begin
					$error("all_done: expected %0d, got %0d", want.all_done, all_done);
					mismatches++;
				end
				if (tick_time !== want.tick) begin
					$error("tick_time: expected %0d, got %0d", want.tick, tick_time);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_cmd(input logic [1:0] op, input logic [ValW-1:0] per,
		input logic [ValW-1:0] bud, input logic [2:0] idx);
		sched_cmd_t c;

		c.op     = op;
		c.period = per;
		c.budget = bud;
		c.index  = idx;
		cmd_queue.push_back(c);
		words_queued++;
		phase_words++;
	endtask

	task automatic wait_quiet();
		while (words_taken != words_queued || due_replies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_policy(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		policy_edf = v;
	endtask

	initial begin
		int              ph;
		int              j;
		int              kind;
		int              n_add;
		int              n_tick;
		int              lim;
		int              pick;
		logic            light;
		logic [ValW-1:0] per;
		logic [ValW-1:0] bud;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_policy(1'b0);
		push_cmd(OP_TICK, 16'hFFFF, 16'hFFFF, 3'd7);    // empty table runs idle
		push_cmd(OP_RETIRE, '0, '0, 3'd7);              // index past the table
		push_cmd(OP_ADD, '0, '0, '0);                   // zero budget
		push_cmd(OP_ADD, 16'd3, 16'd4, '0);             // period below budget
		push_cmd(OP_ADD, 16'hFFFF, 16'hFFFF, 3'd7);
		push_cmd(OP_ADD, 16'd1, 16'd1, '0);
		push_cmd(OP_TICK, '0, '0, '0);
		push_cmd(OP_RETIRE, 16'hFFFF, 16'hFFFF, 3'd0);
		push_cmd(OP_RETIRE, '0, '0, 3'd0);              // second retire counts once
		push_cmd(OP_RETIRE, '0, '0, 3'd1);              // every task retired
		push_cmd(OP_CLEAR, 16'hFFFF, 16'hFFFF, 3'd7);
		// Overloaded pair: the second task misses at time three, then ticks halt.
		push_cmd(OP_ADD, 16'd2, 16'd2, '0);
		push_cmd(OP_ADD, 16'd3, 16'd1, '0);
		for (j = 0; j < 5; j++)
			push_cmd(OP_TICK, '0, '0, '0);
		push_cmd(OP_CLEAR, '0, '0, '0);
		for (j = 0; j < 9; j++)
			push_cmd(OP_ADD, 16'(j + 2), 16'd1, '0);
		wait_quiet();

		for (ph = 0; ph < 8; ph++) begin
			write_policy(!ph[0]);
			case (ph >> 1)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
				default: begin send_idle_pct = 38; recv_stall_pct = 38; end
			endcase
			if (ph == 0)
				holds_asked++;
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				kind = $urandom_range(99);
				if (kind < 85) begin
					// A task session: a fresh table most of the time, a few tasks, then mostly ticks.
					if ($urandom_range(4) != 0)
						push_cmd(OP_CLEAR, 16'($urandom), 16'($urandom), 3'($urandom));
					n_add = $urandom_range(1, 9);
					light = 1'($urandom_range(1));
					for (j = 0; j < n_add; j++) begin
						if ($urandom_range(9) == 0) begin
							per = 16'($urandom);
							bud = $urandom_range(1) ? 16'($urandom) : per >> $urandom_range(15);
						end else begin
							per = 16'($urandom_range(1, 16));
							lim = per / n_add;
							if (lim < 1)
								lim = 1;
							bud = light ? 16'($urandom_range(1, lim)) : 16'($urandom_range(1, per));
						end
						if ($urandom_range(19) == 0)
							bud = '0;
						push_cmd(OP_ADD, per, bud, 3'($urandom));
					end
					n_tick = $urandom_range(4, 40);
					for (j = 0; j < n_tick; j++) begin
						pick = $urandom_range(99);
						if (pick < 8) begin
							push_cmd(OP_RETIRE, 16'($urandom), 16'($urandom), 3'($urandom));
						end else if (pick < 10) begin
							per = 16'($urandom_range(1, 16));
							push_cmd(OP_ADD, per, 16'($urandom_range(1, per)), 3'($urandom));
						end else begin
							push_cmd(OP_TICK, 16'($urandom), 16'($urandom), 3'($urandom));
						end
					end
				end else begin
					n_add = $urandom_range(1, 5);
					for (j = 0; j < n_add; j++)
						push_cmd(2'($urandom), 16'($urandom), 16'($urandom), 3'($urandom));
				end
			end
			wait_quiet();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/pst_pkg.sv
rtl/core/pst_divider.sv
rtl/core/pst_task_table.sv
rtl/core/periodic_task_scheduler_rm_edf_unit.sv
tb/tb_periodic_task_scheduler_rm_edf_unit.sv
